// ===== rtl/wttd_pkg.sv =====
// shared types, constants and tables of the waypoint turn-then-drive controller
package wttd_pkg;

  localparam int CORDIC_STEPS   = 16;
  localparam int WAYPOINT_COUNT = 4;
  localparam int STEP_W         = $clog2(CORDIC_STEPS);
  localparam int IDX_W          = $clog2(WAYPOINT_COUNT);

  localparam int POS_W  = 20;
  localparam int ANG_W  = 16;
  localparam int SPD_W  = 14;
  localparam int TURN_W = 15;
  localparam int CV_W   = 36;   // cordic x and y
  localparam int CZ_W   = 34;   // cordic angle accumulator

  localparam logic signed [POS_W-1:0] SCALED_30  = 20'sd38093;
  localparam logic signed [POS_W-1:0] SCALED_15  = 20'sd19046;
  localparam logic signed [POS_W-1:0] SCALED_M11 = -20'sd13967;
  localparam logic signed [CV_W-1:0]  CORDIC_GAIN_INV = 36'sd652032874;
  localparam logic signed [TURN_W-1:0] TURN_MAX = 15'sd16383;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FORWARD_SPEED = 3'd0,
    REG_TURN_SPEED    = 3'd1,
    REG_GOAL_TOL      = 3'd2,
    REG_HEADING_TOL   = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_ORIGIN_Y      = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQT, S_ATAN_INIT, S_ATAN,
    S_BEAR, S_SIN_INIT, S_SIN, S_TURN, S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_DIFF, CMD_SQX, CMD_SQY, CMD_SQT, CMD_ATAN_INIT,
    CMD_STEP, CMD_BEAR, CMD_SIN_INIT, CMD_TURN, CMD_DECIDE
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [STEP_W-1:0] step;
  } ctrl_t;

  typedef struct packed {
    logic zero_vec;
    logic need_sin;
    logic out_busy;
  } status_t;

  // binary-angle arctangent of 2^-i, 2^32 per turn
  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // goal x: origin plus waypoint offset, wrapped to the position width
  function automatic logic signed [POS_W-1:0] goal_x(input logic signed [POS_W-1:0] org,
                                                     input logic [IDX_W-1:0] idx);
    logic signed [POS_W-1:0] off;
    off = (idx < IDX_W'(2)) ? SCALED_30 : SCALED_15;
    return org + off;
  endfunction

  function automatic logic signed [POS_W-1:0] goal_y(input logic signed [POS_W-1:0] org,
                                                     input logic [IDX_W-1:0] idx);
    logic signed [POS_W-1:0] off;
    off = (idx == IDX_W'(1) || idx == IDX_W'(2)) ? SCALED_M11 : '0;
    return org + off;
  endfunction

endpackage

// ===== rtl/wttd_ctrl.sv =====
// sequencing state machine of the waypoint controller
module wttd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  wttd_pkg::status_t status,
  output wttd_pkg::ctrl_t   ctrl,
  output logic              in_ready
);

  wttd_pkg::state_t state, state_next;
  logic [wttd_pkg::STEP_W-1:0] step, step_next;
  logic last_step;

  assign last_step = (step == wttd_pkg::STEP_W'(wttd_pkg::CORDIC_STEPS - 1));

  // state and iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wttd_pkg::S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    step_next  = step;
    ctrl.cmd   = wttd_pkg::CMD_NONE;
    ctrl.step  = step;
    in_ready   = 1'b0;
    unique case (state)
      wttd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctrl.cmd   = wttd_pkg::CMD_LOAD;
          state_next = wttd_pkg::S_DIFF;
        end
      end
      wttd_pkg::S_DIFF: begin
        ctrl.cmd   = wttd_pkg::CMD_DIFF;
        state_next = wttd_pkg::S_SQX;
      end
      wttd_pkg::S_SQX: begin
        ctrl.cmd   = wttd_pkg::CMD_SQX;
        state_next = wttd_pkg::S_SQY;
      end
      wttd_pkg::S_SQY: begin
        ctrl.cmd   = wttd_pkg::CMD_SQY;
        state_next = wttd_pkg::S_SQT;
      end
      wttd_pkg::S_SQT: begin
        ctrl.cmd   = wttd_pkg::CMD_SQT;
        state_next = status.zero_vec ? wttd_pkg::S_BEAR : wttd_pkg::S_ATAN_INIT;
      end
      wttd_pkg::S_ATAN_INIT: begin
        ctrl.cmd   = wttd_pkg::CMD_ATAN_INIT;
        step_next  = '0;
        state_next = wttd_pkg::S_ATAN;
      end
      wttd_pkg::S_ATAN: begin
        ctrl.cmd  = wttd_pkg::CMD_STEP;
        step_next = step + 1'b1;
        if (last_step) state_next = wttd_pkg::S_BEAR;
      end
      wttd_pkg::S_BEAR: begin
        ctrl.cmd   = wttd_pkg::CMD_BEAR;
        state_next = wttd_pkg::S_SIN_INIT;
      end
      wttd_pkg::S_SIN_INIT: begin
        ctrl.cmd   = wttd_pkg::CMD_SIN_INIT;
        step_next  = '0;
        state_next = status.need_sin ? wttd_pkg::S_SIN : wttd_pkg::S_FINISH;
      end
      wttd_pkg::S_SIN: begin
        ctrl.cmd  = wttd_pkg::CMD_STEP;
        step_next = step + 1'b1;
        if (last_step) state_next = wttd_pkg::S_TURN;
      end
      wttd_pkg::S_TURN: begin
        ctrl.cmd   = wttd_pkg::CMD_TURN;
        state_next = wttd_pkg::S_FINISH;
      end
      wttd_pkg::S_FINISH: begin
        if (!status.out_busy) begin
          ctrl.cmd   = wttd_pkg::CMD_DECIDE;
          state_next = wttd_pkg::S_IDLE;
        end
      end
      default: state_next = wttd_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/wttd_dp.sv =====
// datapath: distance, shared cordic, command decision and result register
module wttd_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  wttd_pkg::ctrl_t                     ctrl,
  output wttd_pkg::status_t                   status,
  input  logic signed [wttd_pkg::POS_W-1:0]   pos_x,
  input  logic signed [wttd_pkg::POS_W-1:0]   pos_y,
  input  logic signed [wttd_pkg::ANG_W-1:0]   heading,
  input  logic                                cfg_fire,
  input  logic [2:0]                          cfg_index,
  input  logic [19:0]                         cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [87:0]                         out_data
);

  // configuration registers
  logic [wttd_pkg::SPD_W-1:0]        forward_speed_set, turn_speed_set;
  logic [15:0]                       goal_tolerance;
  logic [14:0]                       heading_tolerance;
  logic signed [wttd_pkg::POS_W-1:0] origin_x, origin_y;

  // state of the controller
  logic [wttd_pkg::IDX_W-1:0]         waypoint_index;
  logic [wttd_pkg::SPD_W-1:0]         held_forward;
  logic signed [wttd_pkg::TURN_W-1:0] held_turn;

  // working registers
  logic signed [wttd_pkg::POS_W-1:0] px, py;
  logic signed [wttd_pkg::ANG_W-1:0] hd;
  logic signed [20:0]                dx, dy;
  logic signed [43:0]                prod;
  logic [42:0]                       d2;
  logic [31:0]                       t2;
  logic signed [wttd_pkg::CV_W-1:0]  cx, cy;
  logic signed [wttd_pkg::CZ_W-1:0]  cz;
  logic                              rot_mode;
  logic signed [wttd_pkg::ANG_W-1:0] bearing;
  logic signed [50:0]                turn_prod;

  // shared multiplier operands
  logic signed [21:0] mul_a, mul_b;
  always_comb begin
    unique case (ctrl.cmd)
      wttd_pkg::CMD_SQY: begin mul_a = 22'(dy); mul_b = 22'(dy); end
      wttd_pkg::CMD_SQT: begin
        mul_a = $signed({6'b0, goal_tolerance});
        mul_b = $signed({6'b0, goal_tolerance});
      end
      default: begin mul_a = 22'(dx); mul_b = 22'(dx); end
    endcase
  end

  // one cordic micro-rotation
  logic signed [wttd_pkg::CV_W-1:0] xs, ys, cx_step, cy_step;
  logic signed [wttd_pkg::CZ_W-1:0] za, cz_step;
  logic                             dir_pos;
  always_comb begin
    xs = cx >>> ctrl.step;
    ys = cy >>> ctrl.step;
    za = wttd_pkg::CZ_W'(wttd_pkg::atan_at(5'(ctrl.step)));
    // positive direction rotates the vector clockwise in vectoring terms
    dir_pos = rot_mode ? !cz[wttd_pkg::CZ_W-1] : (cy > 0);
    if (rot_mode) begin
      cx_step = dir_pos ? cx - ys : cx + ys;
      cy_step = dir_pos ? cy + xs : cy - xs;
      cz_step = dir_pos ? cz - za : cz + za;
    end else begin
      cx_step = dir_pos ? cx + ys : cx - ys;
      cy_step = dir_pos ? cy - xs : cy + xs;
      cz_step = dir_pos ? cz + za : cz - za;
    end
  end

  // vectoring start: scale by 1024 and fold into the right half plane
  logic signed [wttd_pkg::CV_W-1:0] vx0, vy0;
  assign vx0 = wttd_pkg::CV_W'(dx) <<< 10;
  assign vy0 = wttd_pkg::CV_W'(dy) <<< 10;

  // rotation start: bearing as 32-bit angle folded into plus or minus a quarter turn
  logic signed [wttd_pkg::CZ_W-1:0] zb, zf;
  localparam logic signed [wttd_pkg::CZ_W-1:0] QUARTER = 34'sh040000000;
  localparam logic signed [wttd_pkg::CZ_W-1:0] HALF    = 34'sh080000000;
  always_comb begin
    zb = $signed({{2{bearing[15]}}, bearing, 16'b0});
    if (zb > QUARTER)       zf = HALF - zb;
    else if (zb < -QUARTER) zf = -HALF - zb;
    else                    zf = zb;
  end

  // bearing from the cordic angle, rounded half up
  logic [31:0] ang_rel, ang_rnd;
  assign ang_rel = cz[31:0] - {hd, 16'b0};
  assign ang_rnd = ang_rel + 32'h0000_8000;

  // turn while driving: round half up then saturate
  logic signed [50:0] turn_rnd;
  logic signed [20:0] turn_q;
  logic signed [wttd_pkg::TURN_W-1:0] turn_sat;
  always_comb begin
    turn_rnd = turn_prod + 51'sd536870912;
    turn_q   = 21'(turn_rnd >>> 30);
    if (turn_q > 21'sd16383)       turn_sat = wttd_pkg::TURN_MAX;
    else if (turn_q < -21'sd16383) turn_sat = -wttd_pkg::TURN_MAX;
    else                           turn_sat = 15'(turn_q);
  end

  // decision on the bearing and the distance
  logic [16:0] mag;
  logic        turning, far, near;
  assign mag     = bearing[15] ? 17'(-$signed({bearing[15], bearing})) : 17'(bearing);
  assign turning = mag > 17'(heading_tolerance);
  assign far     = d2 > 43'(t2);
  assign near    = d2 < 43'(t2);

  logic [wttd_pkg::SPD_W-1:0]         fwd_new;
  logic signed [wttd_pkg::TURN_W-1:0] turn_new;
  logic [wttd_pkg::IDX_W-1:0]         idx_new;
  always_comb begin
    fwd_new  = held_forward;
    turn_new = held_turn;
    idx_new  = waypoint_index;
    priority if (turning) begin
      fwd_new  = '0;
      turn_new = bearing[15] ? -$signed({1'b0, turn_speed_set}) : $signed({1'b0, turn_speed_set});
    end else if (far) begin
      fwd_new  = forward_speed_set;
      turn_new = turn_sat;
    end
    if (near) begin
      fwd_new  = '0;
      turn_new = '0;
      idx_new  = waypoint_index + 1'b1;
    end
  end

  assign status.zero_vec = (prod == '0) && (d2 == '0);
  assign status.need_sin = !turning && far;
  assign status.out_busy = out_valid && !out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      forward_speed_set <= 14'd819;
      turn_speed_set    <= 14'd5734;
      goal_tolerance    <= 16'd205;
      heading_tolerance <= 15'd364;
      origin_x          <= 20'sd30720;
      origin_y          <= 20'sd22528;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        wttd_pkg::REG_FORWARD_SPEED: forward_speed_set <= cfg_data[13:0];
        wttd_pkg::REG_TURN_SPEED:    turn_speed_set    <= cfg_data[13:0];
        wttd_pkg::REG_GOAL_TOL:      goal_tolerance    <= cfg_data[15:0];
        wttd_pkg::REG_HEADING_TOL:   heading_tolerance <= cfg_data[14:0];
        wttd_pkg::REG_ORIGIN_X:      origin_x          <= $signed(cfg_data);
        wttd_pkg::REG_ORIGIN_Y:      origin_y          <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // working registers driven by the command
  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      wttd_pkg::CMD_LOAD: begin
        px <= pos_x;
        py <= pos_y;
        hd <= heading;
      end
      wttd_pkg::CMD_DIFF: begin
        dx <= 21'(wttd_pkg::goal_x(origin_x, waypoint_index)) - 21'(px);
        dy <= 21'(wttd_pkg::goal_y(origin_y, waypoint_index)) - 21'(py);
      end
      wttd_pkg::CMD_SQX: prod <= mul_a * mul_b;
      wttd_pkg::CMD_SQY: begin
        d2   <= 43'(prod);
        prod <= mul_a * mul_b;
      end
      wttd_pkg::CMD_SQT: begin
        d2   <= d2 + 43'(prod);
        t2   <= 32'(mul_a * mul_b);
        prod <= '0;
      end
      wttd_pkg::CMD_ATAN_INIT: begin
        rot_mode <= 1'b0;
        if (dx < 0) begin
          cx <= -vx0;
          cy <= -vy0;
          cz <= 34'sh080000000;
        end else begin
          cx <= vx0;
          cy <= vy0;
          cz <= '0;
        end
      end
      wttd_pkg::CMD_STEP: begin
        cx <= cx_step;
        cy <= cy_step;
        cz <= cz_step;
      end
      wttd_pkg::CMD_BEAR: bearing <= status.zero_vec ? '0 : $signed(ang_rnd[31:16]);
      wttd_pkg::CMD_SIN_INIT: begin
        rot_mode <= 1'b1;
        cx       <= wttd_pkg::CORDIC_GAIN_INV;
        cy       <= '0;
        cz       <= zf;
      end
      wttd_pkg::CMD_TURN: turn_prod <= $signed({1'b0, turn_speed_set}) * cy;
      default: ;
    endcase
  end

  // held command, waypoint index and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_index <= '0;
      held_forward   <= '0;
      held_turn      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctrl.cmd == wttd_pkg::CMD_DECIDE) begin
        waypoint_index <= idx_new;
        held_forward   <= fwd_new;
        held_turn      <= turn_new;
        out_valid      <= 1'b1;
        out_data <= {wttd_pkg::goal_y(origin_y, idx_new), wttd_pkg::goal_x(origin_x, idx_new),
                     idx_new, near, bearing, turn_new, fwd_new};
      end
    end
  end

  // a new result only lands in an empty or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.cmd == wttd_pkg::CMD_DECIDE |-> !(out_valid && !out_ready))
    else $error("result register overwritten");

  // arrival always stops the robot
  a_arrive_stop: assert property (@(posedge clk) disable iff (rst)
    ctrl.cmd == wttd_pkg::CMD_DECIDE && near |=> held_forward == '0 && held_turn == '0)
    else $error("arrival without stop");

  // the waypoint index only moves on an arrival
  a_index_move: assert property (@(posedge clk) disable iff (rst)
    waypoint_index != $past(waypoint_index) |->
      $past(ctrl.cmd == wttd_pkg::CMD_DECIDE) && $past(near))
    else $error("waypoint index moved without arrival");

endmodule

// ===== rtl/waypoint_turn_then_drive_controller_core.sv =====
// top level of the waypoint turn-then-drive controller
// Each input transfer is one control tick (robot pose) and yields one result transfer with
// the forward and turn commands, the goal bearing, the arrival flag and the current waypoint.
// An accepted tick is loaded, then the goal differences, the squares, the CORDIC arctangent and
// the bearing follow; when the robot drives, the CORDIC sine and the turn command come
// next. The result becomes valid in the same cycle as the next tick can be taken. When
// the robot stands exactly on the goal the arctangent is skipped. One shared CORDIC unit
// iterates once per cycle for the arctangent and again for the sine, and one multiplier forms
// the squared distances. A finished result waits in an output register, so the next tick is
// taken while it is unread; that tick then stalls in its last cycle until the register is read.
// Configuration writes take effect at once and belong between ticks.
module waypoint_turn_then_drive_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // pos_x, pos_y, heading
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // forward_cmd, turn_cmd, bearing, arrived,
                                      // target_index, target_x, target_y
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  wttd_pkg::ctrl_t   ctrl;
  wttd_pkg::status_t status;
  logic              in_ready;

  assign s_axis_tready = in_ready;
  assign cfg_ready     = 1'b1;

  // sequencer
  wttd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (s_axis_tvalid && in_ready),
    .status   (status),
    .ctrl     (ctrl),
    .in_ready (in_ready)
  );

  // arithmetic and result register
  wttd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .pos_x     ($signed(s_axis_tdata[19:0])),
    .pos_y     ($signed(s_axis_tdata[39:20])),
    .heading   ($signed(s_axis_tdata[55:40])),
    .cfg_fire  (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule
